// ===== rtl/dlxu_pkg.sv =====
package dlxu_pkg;

  // Xorshift128+ shift amounts.
  localparam int unsigned XS_A = 23;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 26;

  // Seed expansion: each generator word is rotl(seed, k) low, rotl(seed, k + 4) high.
  localparam logic [31:0] SEED_RESET   = 32'd1;
  localparam logic [4:0]  ROT_HALF     = 5'd4;
  localparam logic [4:0]  ROT_A_CUR    = 5'd0;
  localparam logic [4:0]  ROT_B_CUR    = 5'd8;
  localparam logic [4:0]  ROT_A_PREV   = 5'd16;
  localparam logic [4:0]  ROT_B_PREV   = 5'd24;

  // Queue between the generator front and the scaling back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic [62:0]        fraction;
    logic signed [31:0] scaled_value;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [62:0]        fraction;
  } job_t;

  typedef struct packed {
    logic [63:0] next;
    logic [62:0] frac;
  } lane_step_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] k);
    logic [63:0] d;
    d = {v, v} << k;
    return d[63:32];
  endfunction

  function automatic logic [63:0] seed_word(input logic [31:0] s, input logic [4:0] k);
    return {rotl32(s, k + ROT_HALF), rotl32(s, k)};
  endfunction

  function automatic lane_step_t lane_step(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    logic [63:0] s;
    lane_step_t  r;
    t      = x ^ (x << XS_A);
    r.next = t ^ y ^ (t >> XS_B) ^ (y >> XS_C);
    s      = r.next + y;
    r.frac = s[63:1];
    return r;
  endfunction

endpackage

// ===== rtl/dlxu_front.sv =====
module dlxu_front
  import dlxu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_stall,
  input  logic        seed_valid,
  input  logic [31:0] seed_data,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [63:0] a_cur;
  logic [63:0] b_cur;
  logic [63:0] a_prev;
  logic [63:0] b_prev;
  logic [62:0] held_fraction;
  logic        hold_flag;

  lane_step_t  a_step;
  lane_step_t  b_step;
  logic        accept;

  assign a_step    = lane_step(a_cur, a_prev);
  assign b_step    = lane_step(b_cur, b_prev);
  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign q_push    = accept;

  always_comb begin
    q_job.range_low  = req.range_low;
    q_job.range_high = req.range_high;
    q_job.fraction   = hold_flag ? held_fraction : a_step.frac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_cur         <= seed_word(SEED_RESET, ROT_A_CUR);
      b_cur         <= seed_word(SEED_RESET, ROT_B_CUR);
      a_prev        <= seed_word(SEED_RESET, ROT_A_PREV);
      b_prev        <= seed_word(SEED_RESET, ROT_B_PREV);
      held_fraction <= '0;
      hold_flag     <= 1'b0;
    end else if (seed_valid) begin
      a_cur     <= seed_word(seed_data, ROT_A_CUR);
      b_cur     <= seed_word(seed_data, ROT_B_CUR);
      a_prev    <= seed_word(seed_data, ROT_A_PREV);
      b_prev    <= seed_word(seed_data, ROT_B_PREV);
      hold_flag <= 1'b0;
    end else if (accept) begin
      if (hold_flag) begin
        hold_flag <= 1'b0;
      end else begin
        a_prev        <= a_cur;
        a_cur         <= a_step.next;
        b_prev        <= b_cur;
        b_cur         <= b_step.next;
        held_fraction <= b_step.frac;
        hold_flag     <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dlxu_queue.sv =====
module dlxu_queue
  import dlxu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dlxu_back.sv =====
module dlxu_back
  import dlxu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  job_t q_head,
  output logic q_pop,
  output logic rsp_valid,
  output rsp_t rsp,
  input  logic rsp_stall
);

  // Stage 1: bound difference as sign and magnitude.
  logic               s1_valid;
  logic signed [31:0] s1_low;
  logic               s1_neg;
  logic [31:0]        s1_mag;
  logic [62:0]        s1_frac;

  // Stage 2: two partial products of magnitude times fraction.
  logic               s2_valid;
  logic signed [31:0] s2_low;
  logic               s2_neg;
  logic [62:0]        s2_frac;
  logic [63:0]        s2_p_lo;
  logic [62:0]        s2_p_hi;

  // Stage 3: quotient by 2^63 and a flag for a nonzero remainder.
  logic               s3_valid;
  logic signed [31:0] s3_low;
  logic               s3_neg;
  logic [62:0]        s3_frac;
  logic [31:0]        s3_q;
  logic               s3_rem_nz;

  logic               advance;
  logic [32:0]        diff_c;
  logic [32:0]        mag_c;
  logic [63:0]        p_lo_c;
  logic [62:0]        p_hi_c;
  logic [95:0]        sum_c;
  logic [31:0]        q_adj_c;
  logic [31:0]        delta_c;

  // The whole pipeline holds while a finished word waits at the output.
  assign advance = !(rsp_valid && rsp_stall);
  assign q_pop   = advance && !q_empty;

  always_comb begin
    diff_c  = {q_head.range_high[31], q_head.range_high}
            - {q_head.range_low[31], q_head.range_low};
    mag_c   = diff_c[32] ? (~diff_c + 33'd1) : diff_c;
    p_lo_c  = s1_mag * s1_frac[31:0];
    p_hi_c  = s1_mag * s1_frac[62:32];
    sum_c   = {1'b0, s2_p_hi, 32'b0} + {32'b0, s2_p_lo};
    // Rounding toward minus infinity on a negative span adds one to the magnitude when the remainder is nonzero.
    q_adj_c = s3_q + {31'b0, s3_neg && s3_rem_nz};
    delta_c = s3_neg ? (~q_adj_c + 32'd1) : q_adj_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      rsp_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_low    <= q_head.range_low;
      s1_neg    <= diff_c[32];
      s1_mag    <= mag_c[31:0];
      s1_frac   <= q_head.fraction;

      s2_low    <= s1_low;
      s2_neg    <= s1_neg;
      s2_frac   <= s1_frac;
      s2_p_lo   <= p_lo_c;
      s2_p_hi   <= p_hi_c;

      s3_low    <= s2_low;
      s3_neg    <= s2_neg;
      s3_frac   <= s2_frac;
      s3_q      <= sum_c[94:63];
      s3_rem_nz <= |sum_c[62:0];

      rsp.fraction     <= s3_frac;
      rsp.scaled_value <= s3_low + delta_c;
    end
  end

endmodule

// ===== rtl/dual_lane_xorshift_uniform_unit.sv =====
// An accepted word passes the queue, scaling stages 1 to 3 and the output register on its way to rsp.
// Throughput: one word per cycle while req_stall and rsp_stall are low; the generator advances on
// every other accepted word and the four-stage scaling multiplier accepts a new word every cycle.
// Reset (rst, synchronous, active high) loads the generator from a seed of one, clears the
// hold flag, and empties the queue and the pipeline; no clearing pass is needed.
module dual_lane_xorshift_uniform_unit
  import dlxu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_stall,
  output logic        rsp_valid,
  output rsp_t        rsp,
  input  logic        rsp_stall,
  input  logic        seed_valid,
  input  logic [31:0] seed_data,
  output logic        seed_ready
);

  // The front owns the generator state. Each accepted word takes a fraction at once:
  // on every other word both lanes advance, lane 0's fraction is used and lane 1's
  // is held for the following word. The bounds and the fraction go into a short queue.
  logic q_push;
  job_t q_push_job;
  logic q_full;
  logic q_pop;
  job_t q_head;
  logic q_empty;

  // A seed write is taken at any time; the user must issue it only with the unit idle, unchecked.
  assign seed_ready = 1'b1;

  dlxu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_stall  (req_stall),
    .seed_valid (seed_valid && seed_ready),
    .seed_data  (seed_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_push_job)
  );

  // The queue lets the front keep taking words while the output is stalled, until its
  // four entries are full, and lets the back drain while no new word arrives.
  dlxu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // The back scales each fraction into the requested range with exact integer
  // arithmetic: low + floor((high - low) * fraction / 2^63), using two partial
  // products of at most 32 by 32 bits and a registered output word.
  dlxu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

endmodule
